// ===== hdl/ols_pkg.sv =====
package ols_pkg;

    localparam int OLS_CAPACITY = 64;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Input tdata: position, word_in, padded to whole bytes.
    localparam int IN_BITS     = POS_W + WORD_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    // Output tdata: word_out, count, is_empty, status, padded to whole bytes.
    localparam int OUT_BITS    = WORD_W + COUNT_W + 1 + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_PUSH     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MODIFY   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RETRIEVE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOVE  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_PUT   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

// ===== hdl/ols_ram.sv =====
module ols_ram #(
    parameter int DEPTH = ols_pkg::OLS_CAPACITY
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [ols_pkg::WORD_W-1:0]       i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [ols_pkg::WORD_W-1:0]       o_rd_data
);
    import ols_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds while the read port is idle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ordered_list_store.sv =====
// Ordered list of up to CAPACITY 64-bit words held in one single-port-read,
// single-port-write memory. Each request (push, insert, erase, modify,
// retrieve, clear) gives exactly one result with the word read, the new
// length, an empty flag and a status. Push, modify, retrieve, clear, insert
// at the end, erase of the last entry and every refused request go straight
// from the input transfer to the done state. Insert at index p on a list
// of length n moves n-p entries; erase at p moves n-p-1 entries. Each
// moved entry costs one memory read and one write, so the worst case is an
// insert at the front of a list one entry short of full. A new request is
// taken once the previous one has reached the output register, even while
// that result still waits for its transfer.
module ordered_list_store #(
    parameter int CAPACITY = ols_pkg::OLS_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [6:0] position, [70:7] word_in, [71] zero
    input  logic [ols_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [2:0] action
    input  logic [ols_pkg::ACTION_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [63:0] word_out, [70:64] count, [71] is_empty, [73:72] status, [79:74] zero
    output logic [ols_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import ols_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_left, n_left;
    logic [AW-1:0]       r_src, n_src;
    logic [AW-1:0]       r_dst, n_dst;
    logic [AW-1:0]       r_pos, n_pos;
    logic [WORD_W-1:0]   r_word, n_word;
    logic                r_up, n_up;
    logic                r_pend;
    logic                r_ret, n_ret;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic                accept;
    logic [ACTION_W-1:0] in_action;
    logic [POS_W-1:0]    in_pos;
    logic [WORD_W-1:0]   in_word;
    logic [CMP_W-1:0]    pos_c, fill_c;
    logic [AW-1:0]       pos_a;
    logic [CW-1:0]       pos_w;
    logic [CW-1:0]       fill_m1;
    logic                is_full;
    logic                out_free;

    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [WORD_W-1:0]   wr_data, rd_data;

    assign in_action = s_axis_tuser;
    assign in_pos    = s_axis_tdata[POS_W-1:0];
    assign in_word   = s_axis_tdata[POS_W +: WORD_W];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign pos_c    = CMP_W'(in_pos);
    assign fill_c   = CMP_W'(r_fill);
    assign pos_a    = pos_c[AW-1:0];
    assign pos_w    = pos_c[CW-1:0];
    assign fill_m1  = r_fill - CW'(1);
    assign is_full  = (r_fill >= FULL_CNT);
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    ols_ram #(
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        logic [CMP_W-1:0] fill_x;

        n_state     = r_state;
        n_fill      = r_fill;
        n_left      = r_left;
        n_src       = r_src;
        n_dst       = r_dst;
        n_pos       = r_pos;
        n_word      = r_word;
        n_up        = r_up;
        n_ret       = r_ret;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        fill_x      = '0;

        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_word;
        rd_en   = 1'b0;
        rd_addr = pos_a;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos    = pos_a;
                    n_word   = in_word;
                    n_ret    = 1'b0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (in_action)
                        ACT_PUSH: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_fill[AW-1:0];
                                wr_data = in_word;
                                n_fill  = r_fill + CW'(1);
                            end
                        end
                        ACT_INSERT: begin
                            if (pos_c > fill_c) begin
                                n_status = ST_RANGE;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_fill = r_fill + CW'(1);
                                if (pos_c == fill_c) begin
                                    wr_en   = 1'b1;
                                    wr_addr = pos_a;
                                    wr_data = in_word;
                                end else begin
                                    // Move the tail up, highest entry first.
                                    n_up    = 1'b1;
                                    n_left  = r_fill - pos_w;
                                    n_src   = fill_m1[AW-1:0];
                                    n_state = S_MOVE;
                                end
                            end
                        end
                        ACT_ERASE: begin
                            if (pos_c >= fill_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_fill = fill_m1;
                                if (fill_m1 != pos_w) begin
                                    // Move the tail down, lowest entry first.
                                    n_up    = 1'b0;
                                    n_left  = fill_m1 - pos_w;
                                    n_src   = pos_a + AW'(1);
                                    n_state = S_MOVE;
                                end
                            end
                        end
                        ACT_MODIFY: begin
                            if (pos_c >= fill_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = pos_a;
                                wr_data = in_word;
                            end
                        end
                        ACT_RETRIEVE: begin
                            if (pos_c >= fill_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = pos_a;
                                n_ret   = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOVE: begin
                // Read one entry per cycle; the entry read in the previous cycle is
                // written to its new place.
                rd_en   = 1'b1;
                rd_addr = r_src;
                wr_en   = r_pend;
                wr_addr = r_dst;
                wr_data = rd_data;
                n_dst   = r_up ? (r_src + AW'(1)) : (r_src - AW'(1));
                n_src   = r_up ? (r_src - AW'(1)) : (r_src + AW'(1));
                n_left  = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                wr_en   = 1'b1;
                wr_addr = r_dst;
                wr_data = rd_data;
                n_state = r_up ? S_PUT : S_DONE;
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_word;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    fill_x      = CMP_W'(r_fill);
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({r_status, (r_fill == '0),
                                                fill_x[COUNT_W-1:0],
                                                (r_ret ? rd_data : '0)});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pend      <= (r_state == S_MOVE);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_pos      <= n_pos;
        r_word     <= n_word;
        r_up       <= n_up;
        r_ret      <= n_ret;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("list length exceeds capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    a_drain_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_pend)
        else $error("drain without a pending shifted word");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

endmodule
